### rtl/triangle_span_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the span rasterizer checker
// Clocked on clk; the plain form is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SPAN_RASTERIZER_ASSERT_SVH
`define TRIANGLE_SPAN_RASTERIZER_ASSERT_SVH

// assertion sampled on clk, off while rst_n is low
`define TSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion sampled on clk, also active during reset
`define TSR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Types and constants shared by the span rasterizer modules.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int COL_W     = 7;
  localparam int ROW_W     = 6;
  localparam int PROD_W    = COL_W + ROW_W;
  localparam int REM_W     = PROD_W + 1;
  localparam int QUO_W     = 8;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int IN_W      = 40;
  localparam int OUT_W     = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_START_A,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_EMIT
  } tsr_state_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic div_start;
    logic edge_long;
    logic capture_a;
    logic capture_b;
    logic emit;
    logic row_inc;
  } tsr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic row_last;
    logic out_full;
  } tsr_stat_t;

endpackage

### rtl/triangle_span_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_span_rasterizer
// Sorts a triangle's vertices by row and emits one inclusive span per row.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | accepted when
//  in_     | in  | tdata: ax, ay, bx, by_row, cx_col, cy_row | in_tvalid & in_tready
//  out_    | out | tdata: span_row, span_start, span_end;    | out_tvalid & out_tready
//          |     | tlast: last_span                          |
//
//  Per triangle: load and sort, then per row short and long edge divisions and a
//  span write. The shared two-bit-per-cycle divider serves both divisions.
//  in_tready is high only between triangles; the final span may still sit in
//  the output register while the next triangle is taken.
//  A stall on out_tready holds the sequencer before it writes the next span.
//  rst_n is synchronous, active low, and clears all control state.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer import tsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // ax[6:0] ay[12:7] bx[19:13] by_row[25:20] cx_col[32:26] cy_row[38:33]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // span_row[5:0] span_start[12:6] span_end[19:13]
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  tsr_cmd_t  cmd;
  tsr_stat_t stat;

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/tsr_div.sv
// ----------------------------------------------------------------------------
// tsr_div
// Restoring unsigned divider, two quotient bits per cycle. The caller
// guarantees the quotient fits QUO_W bits (numerator < 2^QUO_W * divisor).
// ----------------------------------------------------------------------------
module tsr_div import tsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [ROW_W-1:0]  den,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROW_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;

  logic [REM_W-1:0] d_hi, d_lo, r1;
  logic             ge_hi, ge_lo;

  always_comb begin
    d_hi    = {{(REM_W-ROW_W){1'b0}}, den_r} << {cnt_r, 1'b1};
    ge_hi   = rem_r >= d_hi;
    r1      = ge_hi ? rem_r - d_hi : rem_r;
    d_lo    = {{(REM_W-ROW_W){1'b0}}, den_r} << {cnt_r, 1'b0};
    ge_lo   = r1 >= d_lo;
    rem_nxt = ge_lo ? r1 - d_lo : r1;
    quo_nxt = {quo_r[QUO_W-3:0], ge_hi, ge_lo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
      cnt_r <= STEP_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer: sort, then per row short and long edge divisions, a span write.
// ----------------------------------------------------------------------------
module tsr_ctrl import tsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tsr_stat_t stat,
  output tsr_cmd_t  cmd
);

  tsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort  = 1'b1;
        state_nxt = ST_START_A;
      end
      ST_START_A: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (stat.div_done) begin
          // short edge result taken while the long edge starts
          cmd.capture_a = 1'b1;
          cmd.div_start = 1'b1;
          cmd.edge_long = 1'b1;
          state_nxt     = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        if (stat.div_done) begin
          cmd.capture_b = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.out_full) begin
          cmd.emit = 1'b1;
          if (stat.row_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.row_inc = 1'b1;
            state_nxt   = ST_START_A;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/tsr_dp.sv
// ----------------------------------------------------------------------------
// tsr_dp
// Vertex store, sort network, edge setup, shared divider and output register.
// ----------------------------------------------------------------------------
module tsr_dp import tsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  tsr_cmd_t         cmd,
  output tsr_stat_t        stat,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  logic [COL_W-1:0] col_r [3];
  logic [ROW_W-1:0] row_v_r [3];
  logic [ROW_W-1:0] cur_row_r;

  logic [COL_W-1:0] s_col [3];
  logic [ROW_W-1:0] s_row [3];
  logic [COL_W-1:0] tc;
  logic [ROW_W-1:0] tr;

  // three compare-swaps: (0,1), (1,2), (0,1); swap only on strictly greater
  always_comb begin
    s_col = col_r;
    s_row = row_v_r;
    tc    = '0;
    tr    = '0;
    if (s_row[0] > s_row[1]) begin
      tc = s_col[0]; s_col[0] = s_col[1]; s_col[1] = tc;
      tr = s_row[0]; s_row[0] = s_row[1]; s_row[1] = tr;
    end
    if (s_row[1] > s_row[2]) begin
      tc = s_col[1]; s_col[1] = s_col[2]; s_col[2] = tc;
      tr = s_row[1]; s_row[1] = s_row[2]; s_row[2] = tr;
    end
    if (s_row[0] > s_row[1]) begin
      tc = s_col[0]; s_col[0] = s_col[1]; s_col[1] = tc;
      tr = s_row[0]; s_row[0] = s_row[1]; s_row[1] = tr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        col_r[i]   <= '0;
        row_v_r[i] <= '0;
      end
      cur_row_r <= '0;
    end else if (cmd.load) begin
      col_r[0]   <= in_tdata[6:0];
      row_v_r[0] <= in_tdata[12:7];
      col_r[1]   <= in_tdata[19:13];
      row_v_r[1] <= in_tdata[25:20];
      col_r[2]   <= in_tdata[32:26];
      row_v_r[2] <= in_tdata[38:33];
    end else if (cmd.sort) begin
      col_r     <= s_col;
      row_v_r   <= s_row;
      cur_row_r <= s_row[0];
    end else if (cmd.row_inc) begin
      cur_row_r <= cur_row_r + 1'b1;
    end
  end

  // edge setup
  logic [COL_W-1:0]  xs, xe;
  logic [ROW_W-1:0]  ys, ye, dy, dt;
  logic [COL_W:0]    dx;
  logic [COL_W-1:0]  mag;
  logic [PROD_W-1:0] prod;

  always_comb begin
    if (cmd.edge_long) begin
      xs = col_r[0]; ys = row_v_r[0]; xe = col_r[2]; ye = row_v_r[2];
    end else if (cur_row_r < row_v_r[1]) begin
      xs = col_r[0]; ys = row_v_r[0]; xe = col_r[1]; ye = row_v_r[1];
    end else begin
      xs = col_r[1]; ys = row_v_r[1]; xe = col_r[2]; ye = row_v_r[2];
    end
    dx   = {1'b0, xe} - {1'b0, xs};
    dy   = ye - ys;
    dt   = cur_row_r - ys;
    mag  = dx[COL_W] ? COL_W'(-dx) : dx[COL_W-1:0];
    prod = PROD_W'(mag) * PROD_W'(dt);
  end

  logic [COL_W-1:0] e_xs_r;
  logic             e_neg_r, e_flat_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      e_xs_r   <= xs;
      e_neg_r  <= dx[COL_W];
      e_flat_r <= (dy == '0);
    end
  end

  logic             div_done;
  logic [QUO_W-1:0] quo;

  tsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod),
    .den   (dy),
    .done  (div_done),
    .quo   (quo)
  );

  // truncation toward zero: divide the magnitude, apply the sign after
  logic [QUO_W:0]   col_sum;
  logic [COL_W-1:0] edge_col;

  always_comb begin
    if (e_neg_r) begin
      col_sum = {{(QUO_W+1-COL_W){1'b0}}, e_xs_r} - {1'b0, quo};
    end else begin
      col_sum = {{(QUO_W+1-COL_W){1'b0}}, e_xs_r} + {1'b0, quo};
    end
    edge_col = e_flat_r ? e_xs_r : col_sum[COL_W-1:0];
  end

  logic [COL_W-1:0] xa_r, xb_r;

  always_ff @(posedge clk) begin
    if (cmd.capture_a) begin
      xa_r <= edge_col;
    end
    if (cmd.capture_b) begin
      xb_r <= edge_col;
    end
  end

  // output register
  logic             out_valid_r;
  logic [ROW_W-1:0] o_row_r;
  logic [COL_W-1:0] o_start_r, o_end_r;
  logic             o_last_r;
  logic             row_last;

  assign row_last = (cur_row_r == row_v_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_row_r   <= cur_row_r;
      o_start_r <= (xa_r > xb_r) ? xb_r : xa_r;
      o_end_r   <= (xa_r > xb_r) ? xa_r : xb_r;
      o_last_r  <= row_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-ROW_W-2*COL_W){1'b0}}, o_end_r, o_start_r, o_row_r};
  assign out_tlast  = o_last_r;

  assign stat.div_done = div_done;
  assign stat.row_last = row_last;
  assign stat.out_full = out_valid_r && !out_tready;

endmodule

### rtl/tsr_checker.sv
// ----------------------------------------------------------------------------
// tsr_checker
// Port-level checks on the span stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_span_rasterizer_assert.svh"

module tsr_checker import tsr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  // track the row expected after a non-final span
  logic             in_run_r;
  logic [ROW_W-1:0] exp_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r  <= 1'b0;
      exp_row_r <= '0;
    end else if (out_tvalid && out_tready) begin
      in_run_r  <= !out_tlast;
      exp_row_r <= out_tdata[5:0] + 1'b1;
    end
  end

  `TSR_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast),
    "stalled span changed")

  `TSR_ASSERT(a_span_order, out_tvalid |-> out_tdata[19:13] >= out_tdata[12:6],
    "span end left of span start")

  `TSR_ASSERT(a_row_step, out_tvalid && in_run_r |-> out_tdata[5:0] == exp_row_r,
    "span row does not follow previous span")

  `TSR_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid,
    "output valid after reset")

endmodule

bind triangle_span_rasterizer tsr_checker u_tsr_checker (.*);

### sim/triangle_span_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// triangle_span_rasterizer_tb
// Streams triangles into the rasterizer and checks every span it emits
// against spans computed in the bench. Directed corner triangles come first,
// then randomized ones, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer_tb import tsr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 100;
  localparam int N_RANDOM       = 290;
  localparam int MAX_REPORTS    = 30;

  typedef struct {
    logic [COL_W-1:0] ax;
    logic [ROW_W-1:0] ay;
    logic [COL_W-1:0] bx;
    logic [ROW_W-1:0] by_row;
    logic [COL_W-1:0] cx_col;
    logic [ROW_W-1:0] cy_row;
    bit               drain_first;  // hold until all spans so far are back
  } tri_item_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] lo;
    logic [COL_W-1:0] hi;
    logic             last;
  } span_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  tri_item_t pending_tris[$];
  span_t     expected_spans[$];

  int errors = 0;
  int tris_sent = 0;
  int spans_checked = 0;
  int idle_cycles = 0;

  triangle_span_rasterizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // column of edge (xs,ys)-(xe,ye) at row y; division truncates toward zero
  function automatic int edge_x(int xs, int ys, int xe, int ye, int y);
    if (ye == ys) return xs;
    return xs + ((xe - xs) * (y - ys)) / (ye - ys);
  endfunction

  function automatic void rasterize(tri_item_t t);
    int    c[3];
    int    r[3];
    int    i;
    int    tmp;
    int    xa;
    int    xb;
    span_t s;
    c[0] = t.ax;     r[0] = t.ay;
    c[1] = t.bx;     r[1] = t.by_row;
    c[2] = t.cx_col; r[2] = t.cy_row;
    // compare-swap network on pairs (0,1), (1,2), (0,1); strict compare only
    for (int k = 0; k < 3; k++) begin
      i = (k == 1) ? 1 : 0;
      if (r[i] > r[i+1]) begin
        tmp = r[i]; r[i] = r[i+1]; r[i+1] = tmp;
        tmp = c[i]; c[i] = c[i+1]; c[i+1] = tmp;
      end
    end
    for (int y = r[0]; y <= r[2]; y++) begin
      if (y < r[1]) xa = edge_x(c[0], r[0], c[1], r[1], y);
      else          xa = edge_x(c[1], r[1], c[2], r[2], y);
      xb = edge_x(c[0], r[0], c[2], r[2], y);
      if (xa > xb) begin
        tmp = xa; xa = xb; xb = tmp;
      end
      s.row  = ROW_W'(y);
      s.lo   = COL_W'(xa);
      s.hi   = COL_W'(xb);
      s.last = (y == r[2]);
      expected_spans.push_back(s);
    end
  endfunction

  function automatic logic [IN_W-1:0] pack_tri(tri_item_t t);
    return {1'b0, t.cy_row, t.cx_col, t.by_row, t.bx, t.ay, t.ax};
  endfunction

  function automatic void add_tri(int ax, int ay, int bx, int by_r, int cx, int cy,
                                  bit drain);
    tri_item_t t;
    t.ax = COL_W'(ax);  t.ay = ROW_W'(ay);
    t.bx = COL_W'(bx);  t.by_row = ROW_W'(by_r);
    t.cx_col = COL_W'(cx); t.cy_row = ROW_W'(cy);
    t.drain_first = drain;
    pending_tris.push_back(t);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ------------------------------------------------------------------- driver
  int        gap_left = 0;
  int        burst_left = 1;
  tri_item_t cur_tri;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rasterize(cur_tri);
        tris_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_tris.size() > 0 && pending_tris[0].drain_first &&
                     expected_spans.size() > 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          cur_tri = pending_tris.pop_front();
          in_tdata  <= pack_tri(cur_tri);
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 25) : 0;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------- receiver stalling
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       rx_phase = 0;
  int       hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(100, 600);
      end else begin
        mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_OPEN:     out_tready <= 1'b1;
        RX_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_tready <= ((rx_phase % 7) < 3);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
            if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  // ------------------------------------------------------------------ monitor
  span_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_spans.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected span, expected none, actual row %0d cols %0d..%0d",
                   $time, out_tdata[5:0], out_tdata[12:6], out_tdata[19:13]);
      end else begin
        want = expected_spans.pop_front();
        check_field("span_row", want.row, out_tdata[5:0]);
        check_field("span_start", want.lo, out_tdata[12:6]);
        check_field("span_end", want.hi, out_tdata[19:13]);
        check_field("last_span", want.last, out_tlast);
        spans_checked++;
      end
    end
  end

  // ----------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("triangle_span_rasterizer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- stimulus
  int kind;
  int base;
  int r0;
  int r1;
  int r2;

  initial begin
    // degenerate, flat and full-height shapes
    add_tri(0, 0, 0, 0, 0, 0, 1);
    add_tri(127, 63, 127, 63, 127, 63, 0);
    add_tri(100, 20, 5, 20, 127, 20, 0);      // flat: third column ignored
    add_tri(0, 0, 127, 0, 64, 63, 0);         // flat top
    add_tri(64, 0, 0, 63, 127, 63, 0);        // flat bottom
    add_tri(127, 0, 0, 32, 127, 63, 0);
    add_tri(0, 63, 127, 31, 0, 0, 0);
    // all six row orders
    add_tri(20, 10, 90, 20, 50, 30, 0);
    add_tri(20, 10, 90, 30, 50, 20, 0);
    add_tri(20, 20, 90, 10, 50, 30, 0);
    add_tri(20, 20, 90, 30, 50, 10, 0);
    add_tri(20, 30, 90, 10, 50, 20, 0);
    add_tri(20, 30, 90, 20, 50, 10, 0);
    // tied rows in each position
    add_tri(5, 40, 120, 40, 60, 10, 0);
    add_tri(60, 50, 10, 5, 110, 5, 0);
    add_tri(30, 12, 100, 45, 70, 12, 0);
    add_tri(30, 2, 100, 45, 70, 45, 0);
    // negative slopes, checks truncation toward zero
    add_tri(100, 0, 0, 7, 50, 63, 0);
    add_tri(3, 1, 126, 62, 1, 60, 0);
    add_tri(127, 0, 0, 0, 127, 63, 0);
    add_tri(0, 63, 127, 63, 0, 0, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 10) begin
        r0 = $urandom_range(0, 63); r1 = $urandom_range(0, 63); r2 = $urandom_range(0, 63);
      end else if (kind < 15) begin
        // short triangles
        base = $urandom_range(0, 63);
        r0 = base + $urandom_range(0, 6); r1 = base + $urandom_range(0, 6);
        r2 = base + $urandom_range(0, 6);
        if (r0 > 63) r0 = 63;
        if (r1 > 63) r1 = 63;
        if (r2 > 63) r2 = 63;
      end else if (kind < 18) begin
        r0 = $urandom_range(0, 63); r2 = $urandom_range(0, 63);
        r1 = ($urandom_range(0, 1) == 0) ? r0 : r2;
      end else begin
        r0 = $urandom_range(0, 63); r1 = r0; r2 = r0;
      end
      add_tri($urandom_range(0, 127), r0, $urandom_range(0, 127), r1,
              $urandom_range(0, 127), r2, (n % 40) == 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_tris.size() != 0 || in_tvalid || expected_spans.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d triangles (degenerate, flat, tied rows, every row order, random)",
             tris_sent);
    $display("  and checked %0d spans under bursty input and stalled output", spans_checked);
    if (errors == 0 && expected_spans.size() == 0) begin
      $display("triangle_span_rasterizer regression: pass");
    end else begin
      $display("%0d mismatches, %0d spans still expected", errors, expected_spans.size());
      $display("triangle_span_rasterizer regression: fail");
    end
    $finish;
  end

endmodule
